// ----- sv/gyro_still_bias_calibrator_defines.svh -----
// Assertion macros shared by the gyro still bias calibrator RTL.
`ifndef GYRO_STILL_BIAS_CALIBRATOR_DEFINES_SVH
`define GYRO_STILL_BIAS_CALIBRATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GSBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsbc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GSBC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gsbc: next-cycle check failed");

`endif

// ----- sv/gsbc_pkg.sv -----
// Types, widths and constants of the gyro still bias calibrator.
package gsbc_pkg;

    localparam int SAMPLE_TOTAL = 1000;
    localparam int NUM_LANES    = 3;
    localparam int RATE_W       = 16;
    localparam int THRESH_W     = 15;
    localparam int SUM_W        = 32;
    localparam int BIAS_W       = 24;
    localparam int STATUS_W     = 2;
    localparam int SAMPLES_W    = 10;
    localparam int Q_FRAC       = 8;
    localparam int MAX_RATE     = 32767;
    localparam int PIPE_DEPTH   = 5;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(50);

    localparam int COUNT_W   = $clog2(SAMPLE_TOTAL + 1);
    localparam int SUM_MAG_W = $clog2(MAX_RATE * SAMPLE_TOTAL + 1);
    localparam int SCALED_W  = SUM_MAG_W + Q_FRAC;
    localparam logic [63:0] REC = (64'd1 << SCALED_W) / 64'(SAMPLE_TOTAL);
    localparam int REC_W     = $clog2(REC + 64'd1);
    localparam int PROD_W    = SUM_MAG_W + REC_W;
    localparam int REM_W     = $clog2(2 * SAMPLE_TOTAL);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCUM  = 2'd0,
        ST_MOTION = 2'd1,
        ST_DONE   = 2'd2
    } t_status;

    typedef struct packed {
        logic adv;
        logic acc;
        logic clr;
        logic done;
    } t_lane_ctl;

    typedef struct packed {
        t_status               status;
        logic [SAMPLES_W-1:0]  samples;
    } t_meta;

endpackage

// ----- sv/gsbc_qdiv.sv -----
// Pipelined signed divide of a finished sum by the sample total, giving Q8 bias.
module gsbc_qdiv (
    input  logic                               i_clk,
    input  logic                               i_adv,
    input  logic signed [gsbc_pkg::SUM_W-1:0]  i_fin,
    output logic signed [gsbc_pkg::BIAS_W-1:0] o_bias
);

    logic signed [gsbc_pkg::SUM_W-1:0]     w_abs;
    logic [gsbc_pkg::SUM_MAG_W-1:0]        r_mag1;
    logic [gsbc_pkg::SUM_MAG_W-1:0]        r_mag2;
    logic                                  r_neg1;
    logic                                  r_neg2;
    logic                                  r_neg3;
    logic [gsbc_pkg::PROD_W-1:0]           r_prod;
    logic [gsbc_pkg::BIAS_W-1:0]           w_qe;
    logic [gsbc_pkg::SCALED_W-1:0]         w_diff;
    logic [gsbc_pkg::BIAS_W-1:0]           r_qe;
    logic [gsbc_pkg::REM_W-1:0]            r_rem;
    logic [gsbc_pkg::BIAS_W-1:0]           w_q;
    logic signed [gsbc_pkg::BIAS_W-1:0]    r_bias;

    assign w_abs = i_fin[gsbc_pkg::SUM_W-1] ? -i_fin : i_fin;

    // estimate is exact or one low; remainder picks the correction
    assign w_qe   = r_prod[gsbc_pkg::SUM_MAG_W +: gsbc_pkg::BIAS_W];
    assign w_diff = {r_mag2, {gsbc_pkg::Q_FRAC{1'b0}}}
                  - gsbc_pkg::SCALED_W'(w_qe) * gsbc_pkg::SCALED_W'(gsbc_pkg::SAMPLE_TOTAL);
    assign w_q    = r_qe + gsbc_pkg::BIAS_W'(r_rem >= gsbc_pkg::REM_W'(gsbc_pkg::SAMPLE_TOTAL));

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg1 <= i_fin[gsbc_pkg::SUM_W-1];
            r_mag1 <= w_abs[gsbc_pkg::SUM_MAG_W-1:0];
            r_neg2 <= r_neg1;
            r_mag2 <= r_mag1;
            r_prod <= gsbc_pkg::PROD_W'(r_mag1) * gsbc_pkg::PROD_W'(gsbc_pkg::REC);
            r_neg3 <= r_neg2;
            r_qe   <= w_qe;
            r_rem  <= w_diff[gsbc_pkg::REM_W-1:0];
            r_bias <= r_neg3 ? -$signed(w_q) : $signed(w_q);
        end
    end

    assign o_bias = r_bias;

endmodule

// ----- sv/gsbc_lane.sv -----
// One axis lane: motion compare, running sum and bias divide pipeline.
module gsbc_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [gsbc_pkg::RATE_W-1:0]  i_rate,
    input  logic [gsbc_pkg::THRESH_W-1:0]       i_thresh,
    input  gsbc_pkg::t_lane_ctl                 i_ctl,
    output logic                                o_still,
    output logic signed [gsbc_pkg::BIAS_W-1:0]  o_bias
);

    logic [gsbc_pkg::RATE_W:0]             w_ext;
    logic [gsbc_pkg::RATE_W:0]             w_mag;
    logic signed [gsbc_pkg::SUM_W-1:0]     r_sum;
    logic signed [gsbc_pkg::SUM_W-1:0]     w_sum_nxt;
    logic signed [gsbc_pkg::SUM_W-1:0]     r_fin;

    assign w_ext   = {i_rate[gsbc_pkg::RATE_W-1], i_rate};
    assign w_mag   = i_rate[gsbc_pkg::RATE_W-1] ? (~w_ext + 1'b1) : w_ext;
    assign o_still = w_mag < {1'b0, {(gsbc_pkg::RATE_W - gsbc_pkg::THRESH_W){1'b0}}, i_thresh};

    assign w_sum_nxt = r_sum + {{(gsbc_pkg::SUM_W - gsbc_pkg::RATE_W){i_rate[gsbc_pkg::RATE_W-1]}},
                                i_rate};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= w_sum_nxt;
        end
    end

    // only a completing beat carries a sum into the divider
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_fin <= i_ctl.done ? w_sum_nxt : '0;
        end
    end

    gsbc_qdiv u_qdiv (
        .i_clk  (i_clk),
        .i_adv  (i_ctl.adv),
        .i_fin  (r_fin),
        .o_bias (o_bias)
    );

endmodule

// ----- sv/gsbc_merge.sv -----
// Merge of lane motion flags: still count, status, handshake and result pipeline.
`include "gyro_still_bias_calibrator_defines.svh"

module gsbc_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_ready,
    input  logic [gsbc_pkg::NUM_LANES-1:0]         i_still,
    output logic                                   o_ready,
    output logic                                   o_valid,
    output gsbc_pkg::t_lane_ctl                    o_ctl,
    output logic [gsbc_pkg::STATUS_W-1:0]          o_status,
    output logic [gsbc_pkg::SAMPLES_W-1:0]         o_samples_taken
);

    logic                               w_adv;
    logic                               w_accept;
    logic                               w_all_still;
    logic                               w_done;
    logic [gsbc_pkg::COUNT_W-1:0]       r_count;
    logic [gsbc_pkg::COUNT_W-1:0]       w_cnt_nxt;
    gsbc_pkg::t_meta                    w_meta;
    logic [gsbc_pkg::PIPE_DEPTH-1:0]    r_vld;
    gsbc_pkg::t_meta                    r_meta [gsbc_pkg::PIPE_DEPTH];

    assign w_adv       = !r_vld[gsbc_pkg::PIPE_DEPTH-1] || i_ready;
    assign w_accept    = i_valid && w_adv;
    assign w_all_still = &i_still;
    assign w_cnt_nxt   = r_count + 1'b1;
    assign w_done      = w_all_still && (w_cnt_nxt == gsbc_pkg::COUNT_W'(gsbc_pkg::SAMPLE_TOTAL));

    assign o_ctl.adv  = w_adv;
    assign o_ctl.acc  = w_accept && w_all_still && !w_done;
    assign o_ctl.clr  = w_accept && (!w_all_still || w_done);
    assign o_ctl.done = w_accept && w_done;

    always_comb begin
        if (!w_all_still) begin
            w_meta.status  = gsbc_pkg::ST_MOTION;
            w_meta.samples = '0;
        end else begin
            w_meta.status  = w_done ? gsbc_pkg::ST_DONE : gsbc_pkg::ST_ACCUM;
            w_meta.samples = gsbc_pkg::SAMPLES_W'(w_cnt_nxt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= (w_all_still && !w_done) ? w_cnt_nxt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[gsbc_pkg::PIPE_DEPTH-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meta[0] <= w_meta;
            for (int i = 1; i < gsbc_pkg::PIPE_DEPTH; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    assign o_ready         = w_adv;
    assign o_valid         = r_vld[gsbc_pkg::PIPE_DEPTH-1];
    assign o_status        = r_meta[gsbc_pkg::PIPE_DEPTH-1].status;
    assign o_samples_taken = r_meta[gsbc_pkg::PIPE_DEPTH-1].samples;

    `GSBC_ASSERT_IMP(a_count_below_total, i_clk, i_rst_n, 1'b1, r_count < gsbc_pkg::COUNT_W'(gsbc_pkg::SAMPLE_TOTAL))
    `GSBC_ASSERT_NXT(a_motion_clears, i_clk, i_rst_n, w_accept && !w_all_still, r_count == '0)
    `GSBC_ASSERT_IMP(a_acc_clr_excl, i_clk, i_rst_n, 1'b1, !(o_ctl.acc && o_ctl.clr))
    `GSBC_ASSERT_IMP(a_done_full, i_clk, i_rst_n, o_valid && o_status == gsbc_pkg::ST_DONE, o_samples_taken == gsbc_pkg::SAMPLES_W'(gsbc_pkg::SAMPLE_TOTAL))
    `GSBC_ASSERT_IMP(a_motion_zero, i_clk, i_rst_n, o_valid && o_status == gsbc_pkg::ST_MOTION, o_samples_taken == '0)

endmodule

// ----- sv/gyro_still_bias_calibrator.sv -----
// Top level of the gyro still bias calibrator: three axis lanes and the merge stage.
// Throughput: one sample per cycle while the output is not stalled;
// a 5-stage pipeline ends in the divide by the sample total.
// A stalled result holds the whole pipeline, so input ready drops until it is taken.
// Reset (synchronous, active low) sets the threshold to 50 and clears sums, count and valids.
module gyro_still_bias_calibrator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [gsbc_pkg::RATE_W-1:0]  i_rate_x,
    input  logic signed [gsbc_pkg::RATE_W-1:0]  i_rate_y,
    input  logic signed [gsbc_pkg::RATE_W-1:0]  i_rate_z,
    input  logic                                i_cfg_we,
    input  logic [gsbc_pkg::THRESH_W-1:0]       i_cfg_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gsbc_pkg::STATUS_W-1:0]       o_status,
    output logic [gsbc_pkg::SAMPLES_W-1:0]      o_samples_taken,
    output logic signed [gsbc_pkg::BIAS_W-1:0]  o_bias_x,
    output logic signed [gsbc_pkg::BIAS_W-1:0]  o_bias_y,
    output logic signed [gsbc_pkg::BIAS_W-1:0]  o_bias_z
);

    logic [gsbc_pkg::THRESH_W-1:0]       r_thresh;
    logic signed [gsbc_pkg::RATE_W-1:0]  w_rate [gsbc_pkg::NUM_LANES];
    logic signed [gsbc_pkg::BIAS_W-1:0]  w_bias [gsbc_pkg::NUM_LANES];
    logic [gsbc_pkg::NUM_LANES-1:0]      w_still;
    gsbc_pkg::t_lane_ctl                 w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= gsbc_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_data;
        end
    end

    assign w_rate[0] = i_rate_x;
    assign w_rate[1] = i_rate_y;
    assign w_rate[2] = i_rate_z;

    for (genvar g = 0; g < gsbc_pkg::NUM_LANES; g++) begin : g_lane
        gsbc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_rate   (w_rate[g]),
            .i_thresh (r_thresh),
            .i_ctl    (w_ctl),
            .o_still  (w_still[g]),
            .o_bias   (w_bias[g])
        );
    end

    gsbc_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ready         (i_ready),
        .i_still         (w_still),
        .o_ready         (o_ready),
        .o_valid         (o_valid),
        .o_ctl           (w_ctl),
        .o_status        (o_status),
        .o_samples_taken (o_samples_taken)
    );

    assign o_bias_x = w_bias[0];
    assign o_bias_y = w_bias[1];
    assign o_bias_z = w_bias[2];

endmodule
